FILE: src/pds_pkg.sv
package pds_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_FIRE        = 16;
    localparam int FIRE_W          = $clog2(MAX_FIRE);

    localparam int TIME_W   = 40;
    localparam int PERIOD_W = 32;
    localparam int ID_W     = 8;
    localparam int KIND_W   = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;
    localparam logic [1:0] FUNC_CLOSE  = 2'd3;

    localparam logic [KIND_W-1:0] RES_FIRED      = 3'd0;
    localparam logic [KIND_W-1:0] RES_ADDED      = 3'd1;
    localparam logic [KIND_W-1:0] RES_FULL       = 3'd2;
    localparam logic [KIND_W-1:0] RES_CLOSED     = 3'd3;
    localparam logic [KIND_W-1:0] RES_CANCELLED  = 3'd4;
    localparam logic [KIND_W-1:0] RES_NOT_FOUND  = 3'd5;

    typedef struct packed {
        logic                is_tick;
        logic                is_add;
        logic                is_cancel;
        logic                is_close;
        logic [ID_W-1:0]     task_id;
        logic [PERIOD_W-1:0] start_delay;
        logic [PERIOD_W-1:0] period;
    } t_cmd;

    typedef struct packed {
        logic [6:0] count;
        logic       busy;
    } t_status;

endpackage

FILE: src/periodic_deadline_scheduler.sv
// Deadline-sorted timer queue with a millisecond clock. Commands enter a
// two-deep queue and are carried out one at a time. A cancel removes every
// entry with its task id, one entry at a time. A tick fires up to sixteen due
// entries, one at a time, then re-arms each periodic one; when the re-armed
// deadline lags, the bit-serial remainder unit (40 steps) works out how many
// periods to skip.
module periodic_deadline_scheduler #(
    parameter int QUEUE_DEPTH = pds_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_func,
    input  logic [pds_pkg::ID_W-1:0]      i_task_id,
    input  logic [pds_pkg::PERIOD_W-1:0]  i_start_delay,
    input  logic [pds_pkg::PERIOD_W-1:0]  i_period,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pds_pkg::KIND_W-1:0]    o_result_kind,
    output logic [pds_pkg::ID_W-1:0]      o_result_task,
    output logic [pds_pkg::TIME_W-1:0]    o_fire_time,
    output logic                          o_last_result
);

    logic             w_cmd_valid;
    logic             w_cmd_pop;
    pds_pkg::t_cmd    w_cmd;
    pds_pkg::t_status w_status;

    pds_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_task_id     (i_task_id),
        .i_start_delay (i_start_delay),
        .i_period      (i_period),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    pds_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_result_task (o_result_task),
        .o_fire_time   (o_fire_time),
        .o_last_result (o_last_result),
        .o_status      (w_status)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.count <= 7'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind != pds_pkg::RES_FIRED) |-> o_last_result)
        else $error("non-fire result not marked last");

    a_no_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind != pds_pkg::RES_FIRED) |-> (o_fire_time == '0))
        else $error("fire time on non-fire result");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_status.busy && w_cmd_valid)
        else $error("command taken while busy");

endmodule

FILE: src/pds_front.sv
module pds_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_func,
    input  logic [pds_pkg::ID_W-1:0]      i_task_id,
    input  logic [pds_pkg::PERIOD_W-1:0]  i_start_delay,
    input  logic [pds_pkg::PERIOD_W-1:0]  i_period,
    output logic                          o_cmd_valid,
    output pds_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_pop
);

    pds_pkg::t_cmd r_buf [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    pds_pkg::t_cmd w_cls;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_cls             = '0;
        w_cls.task_id     = i_task_id;
        w_cls.start_delay = i_start_delay;
        w_cls.period      = i_period;
        unique case (i_func)
            pds_pkg::FUNC_TICK:   w_cls.is_tick   = 1'b1;
            pds_pkg::FUNC_ADD:    w_cls.is_add    = 1'b1;
            pds_pkg::FUNC_CANCEL: w_cls.is_cancel = 1'b1;
            default:              w_cls.is_close  = 1'b1;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_buf[r_rp];
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_buf[r_wp] <= w_cls;
    end

endmodule

FILE: src/pds_rem.sv
module pds_rem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pds_pkg::TIME_W-1:0]    i_num,
    input  logic [pds_pkg::PERIOD_W-1:0]  i_den,
    output logic                          o_done,
    output logic [pds_pkg::PERIOD_W-1:0]  o_rem
);

    localparam int SW = $clog2(pds_pkg::TIME_W + 1);

    logic [pds_pkg::TIME_W-1:0]   r_num;
    logic [pds_pkg::PERIOD_W:0]   r_rem;
    logic [pds_pkg::PERIOD_W-1:0] r_den;
    logic [SW-1:0]                r_step;
    logic                         r_done;
    logic [pds_pkg::PERIOD_W:0]   w_trial;

    assign w_trial = {r_rem[pds_pkg::PERIOD_W-1:0], r_num[pds_pkg::TIME_W-1]};
    assign o_done  = r_done;
    assign o_rem   = r_rem[pds_pkg::PERIOD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_step == SW'(1));
            if (i_start) begin
                r_step <= SW'(pds_pkg::TIME_W);
            end else if (r_step != '0) begin
                r_step <= r_step - SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_step != '0) begin
            r_num <= {r_num[pds_pkg::TIME_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) r_rem <= w_trial - {1'b0, r_den};
            else                          r_rem <= w_trial;
        end
    end

endmodule

FILE: src/pds_back.sv
module pds_back #(
    parameter int QUEUE_DEPTH = pds_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  pds_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pds_pkg::KIND_W-1:0]    o_result_kind,
    output logic [pds_pkg::ID_W-1:0]      o_result_task,
    output logic [pds_pkg::TIME_W-1:0]    o_fire_time,
    output logic                          o_last_result,
    output pds_pkg::t_status              o_status
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int FW = pds_pkg::FIRE_W;
    localparam int TW = pds_pkg::TIME_W;
    localparam int PW = pds_pkg::PERIOD_W;
    localparam int IW = pds_pkg::ID_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_TICK    = 3'd1;
    localparam logic [2:0] S_RA_CALC = 3'd2;
    localparam logic [2:0] S_RA_DIV  = 3'd3;
    localparam logic [2:0] S_RA_INS  = 3'd4;
    localparam logic [2:0] S_CANCEL  = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    logic [TW-1:0] r_dl [QUEUE_DEPTH];
    logic [PW-1:0] r_pe [QUEUE_DEPTH];
    logic [IW-1:0] r_id [QUEUE_DEPTH];
    logic [TW-1:0] n_dl [QUEUE_DEPTH];
    logic [PW-1:0] n_pe [QUEUE_DEPTH];
    logic [IW-1:0] n_id [QUEUE_DEPTH];

    logic [TW-1:0] r_fd [pds_pkg::MAX_FIRE];
    logic [PW-1:0] r_fp [pds_pkg::MAX_FIRE];
    logic [IW-1:0] r_fi [pds_pkg::MAX_FIRE];

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [TW-1:0]     r_now, n_now;
    logic              r_closed, n_closed;
    logic [FW:0]       r_nfire, n_nfire;
    logic [FW:0]       r_npush, n_npush;
    logic [FW:0]       r_ri, n_ri;
    logic [TW-1:0]     r_rd, n_rd;
    logic [IW-1:0]     r_task, n_task;
    logic              r_found, n_found;
    logic [pds_pkg::KIND_W-1:0] r_pkind, n_pkind;

    logic              r_ov;
    logic [pds_pkg::KIND_W-1:0] r_okind;
    logic [IW-1:0]     r_otask;
    logic [TW-1:0]     r_otime;
    logic              r_olast;

    logic              w_out_free;
    logic              w_emit;
    logic [pds_pkg::KIND_W-1:0] w_ekind;
    logic [IW-1:0]     w_etask;
    logic [TW-1:0]     w_etime;
    logic              w_elast;

    logic              w_ins, w_pop, w_rm, w_fpush;
    logic [TW-1:0]     w_ins_d;
    logic [PW-1:0]     w_ins_p;
    logic [IW-1:0]     w_ins_id;
    logic [QUEUE_DEPTH-1:0] w_keep, w_match, w_ge;
    logic              w_head_due, w_next_due;
    logic [TW:0]       w_sum_add, w_sum_ra;
    logic [TW-1:0]     w_sat_add, w_sat_ra;
    logic              w_div_start;
    logic [TW-1:0]     w_div_num;
    logic              w_div_done;
    logic [PW-1:0]     w_div_rem;
    logic [FW-1:0]     w_rix;

    pds_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_fp[w_rix]),
        .o_done  (w_div_done),
        .o_rem   (w_div_rem)
    );

    assign w_rix      = r_ri[FW-1:0];
    assign w_out_free = !r_ov || !i_out_stall;
    assign w_head_due = (r_cnt != '0) && (r_dl[0] <= r_now);
    assign w_next_due = (r_cnt > CW'(1)) && (r_dl[1] <= r_now);
    assign w_sum_add  = {1'b0, r_now} + {{(TW+1-PW){1'b0}}, i_cmd.start_delay};
    assign w_sat_add  = w_sum_add[TW] ? pds_pkg::TIME_MAX : w_sum_add[TW-1:0];
    assign w_sum_ra   = {1'b0, r_fd[w_rix]} + {{(TW+1-PW){1'b0}}, r_fp[w_rix]};
    assign w_sat_ra   = w_sum_ra[TW] ? pds_pkg::TIME_MAX : w_sum_ra[TW-1:0];
    assign w_div_num  = r_now - w_sat_ra;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_keep[i]  = (CW'(i) < r_cnt) && (w_ins_d > r_dl[i]);
            w_match[i] = (CW'(i) < r_cnt) && (r_id[i] == r_task);
            if (i == 0) w_ge[i] = w_match[i];
            else        w_ge[i] = w_ge[i-1] || w_match[i];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_now       = r_now;
        n_closed    = r_closed;
        n_nfire     = r_nfire;
        n_npush     = r_npush;
        n_ri        = r_ri;
        n_rd        = r_rd;
        n_task      = r_task;
        n_found     = r_found;
        n_pkind     = r_pkind;
        o_cmd_pop   = 1'b0;
        w_emit      = 1'b0;
        w_ekind     = r_pkind;
        w_etask     = r_task;
        w_etime     = '0;
        w_elast     = 1'b1;
        w_ins       = 1'b0;
        w_pop       = 1'b0;
        w_rm        = 1'b0;
        w_fpush     = 1'b0;
        w_ins_d     = r_rd;
        w_ins_p     = r_fp[w_rix];
        w_ins_id    = r_fi[w_rix];
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_task    = i_cmd.task_id;
                    if (i_cmd.is_tick) begin
                        n_nfire = '0;
                        n_npush = '0;
                        n_ri    = '0;
                        n_state = S_TICK;
                    end else if (i_cmd.is_add) begin
                        n_state = S_EMIT;
                        if (r_closed) begin
                            n_pkind = pds_pkg::RES_CLOSED;
                        end else if (r_cnt == CW'(QUEUE_DEPTH)) begin
                            n_pkind = pds_pkg::RES_FULL;
                        end else begin
                            n_pkind  = pds_pkg::RES_ADDED;
                            w_ins    = 1'b1;
                            w_ins_d  = w_sat_add;
                            w_ins_p  = i_cmd.period;
                            w_ins_id = i_cmd.task_id;
                        end
                    end else if (i_cmd.is_cancel) begin
                        n_found = 1'b0;
                        n_state = S_CANCEL;
                    end else begin
                        n_cnt    = '0;
                        n_closed = 1'b1;
                    end
                end
            end
            S_TICK: begin
                if (w_head_due && (r_nfire != (FW+1)'(pds_pkg::MAX_FIRE))) begin
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        w_ekind = pds_pkg::RES_FIRED;
                        w_etask = r_id[0];
                        w_etime = r_dl[0];
                        w_elast = !(w_next_due &&
                                    (r_nfire != (FW+1)'(pds_pkg::MAX_FIRE - 1)));
                        w_pop   = 1'b1;
                        n_nfire = r_nfire + (FW+1)'(1);
                        if (r_pe[0] != '0) begin
                            w_fpush = 1'b1;
                            n_npush = r_npush + (FW+1)'(1);
                        end
                    end
                end else begin
                    n_state = S_RA_CALC;
                end
            end
            S_RA_CALC: begin
                if (r_ri == r_npush) begin
                    n_now   = r_now + TW'(1);
                    n_state = S_IDLE;
                end else begin
                    n_rd = w_sat_ra;
                    if (r_now > w_sat_ra) begin
                        w_div_start = 1'b1;
                        n_state     = S_RA_DIV;
                    end else begin
                        n_state = S_RA_INS;
                    end
                end
            end
            S_RA_DIV: begin
                if (w_div_done) begin
                    n_rd    = r_now - {{(TW-PW){1'b0}}, w_div_rem};
                    n_state = S_RA_INS;
                end
            end
            S_RA_INS: begin
                w_ins   = 1'b1;
                n_ri    = r_ri + (FW+1)'(1);
                n_state = S_RA_CALC;
            end
            S_CANCEL: begin
                if (w_ge[QUEUE_DEPTH-1]) begin
                    w_rm    = 1'b1;
                    n_found = 1'b1;
                end else begin
                    n_pkind = r_found ? pds_pkg::RES_CANCELLED : pds_pkg::RES_NOT_FOUND;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_dl[i] = r_dl[i];
            n_pe[i] = r_pe[i];
            n_id[i] = r_id[i];
        end
        if (w_ins) begin
            n_cnt = r_cnt + CW'(1);
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (!w_keep[i]) begin
                    if (i == 0 || w_keep[(i == 0) ? 0 : i-1]) begin
                        n_dl[i] = w_ins_d;
                        n_pe[i] = w_ins_p;
                        n_id[i] = w_ins_id;
                    end else begin
                        n_dl[i] = r_dl[(i == 0) ? 0 : i-1];
                        n_pe[i] = r_pe[(i == 0) ? 0 : i-1];
                        n_id[i] = r_id[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end else if (w_pop || w_rm) begin
            n_cnt = r_cnt - CW'(1);
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                if (w_pop || w_ge[i]) begin
                    n_dl[i] = r_dl[i+1];
                    n_pe[i] = r_pe[i+1];
                    n_id[i] = r_id[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_now    <= '0;
            r_closed <= 1'b0;
            r_nfire  <= '0;
            r_npush  <= '0;
            r_ri     <= '0;
            r_found  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_now    <= n_now;
            r_closed <= n_closed;
            r_nfire  <= n_nfire;
            r_npush  <= n_npush;
            r_ri     <= n_ri;
            r_found  <= n_found;
            if (w_emit)           r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd    <= n_rd;
        r_task  <= n_task;
        r_pkind <= n_pkind;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_dl[i] <= n_dl[i];
            r_pe[i] <= n_pe[i];
            r_id[i] <= n_id[i];
        end
        if (w_fpush) begin
            r_fd[r_npush[FW-1:0]] <= r_dl[0];
            r_fp[r_npush[FW-1:0]] <= r_pe[0];
            r_fi[r_npush[FW-1:0]] <= r_id[0];
        end
        if (w_emit) begin
            r_okind <= w_ekind;
            r_otask <= w_etask;
            r_otime <= w_etime;
            r_olast <= w_elast;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_result_kind  = r_okind;
    assign o_result_task  = r_otask;
    assign o_fire_time    = r_otime;
    assign o_last_result  = r_olast;
    assign o_status.count = 7'(r_cnt);
    assign o_status.busy  = (r_state != S_IDLE);

endmodule

FILE: dv/tb_periodic_deadline_scheduler.sv
`timescale 1ns / 1ps

module tb_periodic_deadline_scheduler;

    localparam int DEPTH    = pds_pkg::QUEUE_DEPTH_DEF;
    localparam int MAX_FIRE = pds_pkg::MAX_FIRE;
    localparam int ID_W     = pds_pkg::ID_W;
    localparam int PERIOD_W = pds_pkg::PERIOD_W;
    localparam int TIME_W   = pds_pkg::TIME_W;
    localparam int KIND_W   = pds_pkg::KIND_W;

    typedef struct packed {
        logic [1:0]          func;
        logic [ID_W-1:0]     task_id;
        logic [PERIOD_W-1:0] start_delay;
        logic [PERIOD_W-1:0] period;
    } t_txn;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] fire_time;
        logic              last;
    } t_res;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          func = pds_pkg::FUNC_TICK;
    logic [ID_W-1:0]     task_id = '0;
    logic [PERIOD_W-1:0] start_delay = '0;
    logic [PERIOD_W-1:0] period = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [KIND_W-1:0]   result_kind;
    logic [ID_W-1:0]     result_task;
    logic [TIME_W-1:0]   fire_time;
    logic                last_result;

    periodic_deadline_scheduler i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_func(func), .i_task_id(task_id),
        .i_start_delay(start_delay), .i_period(period),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_result_kind(result_kind), .o_result_task(result_task),
        .o_fire_time(fire_time), .o_last_result(last_result)
    );

    always #2 i_clk = ~i_clk;

    t_txn pending_txns[$];
    t_res expected_results[$];
    int   mismatches = 0;
    int   checked = 0;
    int   txns_sent = 0;
    bit   calm = 1'b0;

    // scheduler mirror
    logic [TIME_W-1:0]   sch_deadline[DEPTH];
    logic [PERIOD_W-1:0] sch_period[DEPTH];
    logic [ID_W-1:0]     sch_id[DEPTH];
    int                  sch_count = 0;
    logic [TIME_W-1:0]   sch_now = '0;
    bit                  sch_closed = 1'b0;

    function automatic void queue_insert(logic [TIME_W-1:0] d, logic [PERIOD_W-1:0] p,
                                         logic [ID_W-1:0] id);
        int pos;
        pos = sch_count;
        while (pos > 0 && !(d > sch_deadline[pos-1])) begin
            sch_deadline[pos] = sch_deadline[pos-1];
            sch_period[pos] = sch_period[pos-1];
            sch_id[pos] = sch_id[pos-1];
            pos--;
        end
        sch_deadline[pos] = d;
        sch_period[pos] = p;
        sch_id[pos] = id;
        sch_count++;
    endfunction

    function automatic logic [TIME_W-1:0] next_deadline(logic [TIME_W-1:0] d,
                                                      logic [PERIOD_W-1:0] p);
        logic [TIME_W:0] s;
        logic [TIME_W-1:0] r;
        s = {1'b0, d} + p;
        r = s[TIME_W] ? pds_pkg::TIME_MAX : s[TIME_W-1:0];
        if (sch_now > r) r = r + p * ((sch_now - r) / p);
        return r;
    endfunction

    function automatic void push_result(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                        logic [TIME_W-1:0] t);
        t_res r;
        r.kind = k;
        r.task_id = id;
        r.fire_time = t;
        r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_schedule(t_txn t);
        logic [TIME_W-1:0]   fd[MAX_FIRE];
        logic [PERIOD_W-1:0] fp[MAX_FIRE];
        logic [ID_W-1:0]     fi[MAX_FIRE];
        logic [TIME_W:0]     s;
        int due, w, n;
        bit hit;
        n = expected_results.size();
        case (t.func)
            pds_pkg::FUNC_TICK: begin
                due = 0;
                while (due < sch_count && due < MAX_FIRE && sch_deadline[due] <= sch_now)
                    due++;
                for (int i = 0; i < due; i++) begin
                    fd[i] = sch_deadline[i];
                    fp[i] = sch_period[i];
                    fi[i] = sch_id[i];
                end
                for (int i = due; i < sch_count; i++) begin
                    sch_deadline[i-due] = sch_deadline[i];
                    sch_period[i-due] = sch_period[i];
                    sch_id[i-due] = sch_id[i];
                end
                sch_count -= due;
                for (int i = 0; i < due; i++) push_result(pds_pkg::RES_FIRED, fi[i], fd[i]);
                for (int i = 0; i < due; i++)
                    if (fp[i] != 0 && sch_count < DEPTH)
                        queue_insert(next_deadline(fd[i], fp[i]), fp[i], fi[i]);
                sch_now = sch_now + 1'b1;
            end
            pds_pkg::FUNC_ADD: begin
                if (sch_closed) push_result(pds_pkg::RES_CLOSED, t.task_id, '0);
                else if (sch_count >= DEPTH) push_result(pds_pkg::RES_FULL, t.task_id, '0);
                else begin
                    s = {1'b0, sch_now} + t.start_delay;
                    queue_insert(s[TIME_W] ? pds_pkg::TIME_MAX : s[TIME_W-1:0],
                                 t.period, t.task_id);
                    push_result(pds_pkg::RES_ADDED, t.task_id, '0);
                end
            end
            pds_pkg::FUNC_CANCEL: begin
                w = 0;
                hit = 1'b0;
                for (int r = 0; r < sch_count; r++) begin
                    if (sch_id[r] == t.task_id) hit = 1'b1;
                    else begin
                        sch_deadline[w] = sch_deadline[r];
                        sch_period[w] = sch_period[r];
                        sch_id[w] = sch_id[r];
                        w++;
                    end
                end
                sch_count = w;
                push_result(hit ? pds_pkg::RES_CANCELLED : pds_pkg::RES_NOT_FOUND,
                            t.task_id, '0);
            end
            default: begin
                sch_count = 0;
                sch_closed = 1'b1;
            end
        endcase
        if (expected_results.size() > n)
            expected_results[expected_results.size()-1].last = 1'b1;
    endfunction

    function automatic t_txn mk(logic [1:0] f, logic [ID_W-1:0] id,
                                logic [PERIOD_W-1:0] d, logic [PERIOD_W-1:0] p);
        t_txn t;
        t.func = f;
        t.task_id = id;
        t.start_delay = d;
        t.period = p;
        return t;
    endfunction

    function automatic logic [PERIOD_W-1:0] rand_span();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return '1;
            2: return 32'h8000_0000 | $urandom();
            default: return $urandom_range(0, 6);
        endcase
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 13);
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_txn t;
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                predict_schedule(pending_txns[0]);
                pending_txns.delete(0);
                txns_sent++;
            end
            if (!(in_valid && in_stall)) begin
                if (pending_txns.size() > 0 && !idle_now()) begin
                    t = pending_txns[0];
                    in_valid <= 1'b1;
                    func <= t.func;
                    task_id <= t.task_id;
                    start_delay <= t.start_delay;
                    period <= t.period;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                got = '{result_kind, result_task, fire_time, last_result};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d task %0d time %0d last %0b",
                                 got.kind, got.task_id, got.fire_time, got.last);
                end else begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    checked++;
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected kind %0d task %0d time %0d last %0b,",
                                      " got kind %0d task %0d time %0d last %0b"},
                                     exp_r.kind, exp_r.task_id, exp_r.fire_time, exp_r.last,
                                     got.kind, got.task_id, got.fire_time, got.last);
                    end
                end
            end
            out_stall <= idle_now();
        end
    end

    initial begin
        int n_txn, r;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        pending_txns.push_back(mk(pds_pkg::FUNC_TICK, 8'd0, 0, 0));
        pending_txns.push_back(mk(pds_pkg::FUNC_CANCEL, 8'd7, 0, 0));
        pending_txns.push_back(mk(pds_pkg::FUNC_ADD, 8'd1, 0, 0));
        pending_txns.push_back(mk(pds_pkg::FUNC_ADD, 8'd2, 0, 1));
        pending_txns.push_back(mk(pds_pkg::FUNC_ADD, 8'd3, 0, 0));
        pending_txns.push_back(mk(pds_pkg::FUNC_ADD, 8'hFF, '1, '1));
        pending_txns.push_back(mk(pds_pkg::FUNC_ADD, 8'd5, 3, 2));
        pending_txns.push_back(mk(pds_pkg::FUNC_TICK, 8'hFF, '1, '1));
        pending_txns.push_back(mk(pds_pkg::FUNC_TICK, 8'd0, 0, 0));
        pending_txns.push_back(mk(pds_pkg::FUNC_TICK, 8'd0, 0, 0));
        pending_txns.push_back(mk(pds_pkg::FUNC_TICK, 8'd0, 0, 0));
        pending_txns.push_back(mk(pds_pkg::FUNC_CANCEL, 8'd2, 0, 0));
        for (int i = 0; i < 13; i++)
            pending_txns.push_back(mk(pds_pkg::FUNC_ADD, 8'd9, 0, 3));
        pending_txns.push_back(mk(pds_pkg::FUNC_ADD, 8'd10, 1, 1));
        pending_txns.push_back(mk(pds_pkg::FUNC_TICK, 8'd0, 0, 0));
        pending_txns.push_back(mk(pds_pkg::FUNC_CANCEL, 8'd9, 0, 0));
        pending_txns.push_back(mk(pds_pkg::FUNC_CANCEL, 8'hFF, 0, 0));

        // random: mostly adds and ticks with small spans, close once near the end
        n_txn = 0;
        while (n_txn < 390) begin
            r = $urandom_range(0, 99);
            if (n_txn == 360)
                pending_txns.push_back(mk(pds_pkg::FUNC_CLOSE, ID_W'($urandom()),
                                          $urandom(), $urandom()));
            else if (r < 40)
                pending_txns.push_back(mk(pds_pkg::FUNC_ADD,
                                          ID_W'($urandom_range(0, 15) |
                                                ($urandom_range(0, 7) == 0 ? $urandom() : 0)),
                                          rand_span(), rand_span()));
            else if (r < 85)
                pending_txns.push_back(mk(pds_pkg::FUNC_TICK, ID_W'($urandom()),
                                          $urandom(), $urandom()));
            else
                pending_txns.push_back(mk(pds_pkg::FUNC_CANCEL, ID_W'($urandom_range(0, 15)),
                                          $urandom(), $urandom()));
            n_txn++;
            if (n_txn == 150) begin
                while (pending_txns.size() != 0) @(posedge i_clk);
                calm = 1'b1;
            end
            if (n_txn == 250) begin
                while (pending_txns.size() != 0) @(posedge i_clk);
                calm = 1'b0;
            end
        end

        while (pending_txns.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        $display("%0d transactions sent, %0d results checked, %0d mismatches",
                 txns_sent, checked, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("periodic_deadline_scheduler regression: pass");
        else
            $display("periodic_deadline_scheduler regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("periodic_deadline_scheduler regression: fail");
        $finish;
    end
endmodule
